>>> sv/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg
// Shared widths and register indices for the escape-time counter.
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int STEP_W     = 30;
    localparam int HEIGHT_W   = 13;
    localparam int GRAY_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 30;

    localparam logic [STEP_W-1:0]   STEP_RESET   = 30'd655360;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_STEP   = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

>>> sv/mandelbrot_escape_counter.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter
// Escape-time evaluation of one pixel, built around a single shared multiplier.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+-----------------------------
//  in       | input     | i_in_valid / o_in_stall  | i_pixel_x, i_pixel_y
//  out      | output    | o_out_valid / i_out_stall| o_gray_level, o_escaped
//  cfg      | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
//  A pixel forms c in states S_C0 to S_C3, then runs rounds of z = z^2 + c
//  through S_XX, S_YY, S_XY and S_UPD until it escapes or reaches
//  MAX_ITERATIONS rounds, and hands its result on from S_DONE.
//  Each round uses the one multiplier three times, for zx^2, zy^2 and zx*zy.
//  The result goes to an output register, so the next pixel is taken while it waits.
//  Reset is synchronous and active low; it restores the register defaults.
//  A stalled result stays in the output register; a second finished pixel
//  waits in the final state until that register is free.
// ----------------------------------------------------------------------------
module mandelbrot_escape_counter
    import mec_pkg::*;
#(
    parameter int MAX_ITERATIONS = 255,
    parameter int COORD_BITS     = 12,
    parameter int FRACTION_BITS  = 28
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [GRAY_W-1:0]     o_gray_level,
    output logic                  o_escaped,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Q4.F word, multiplier operand (wide enough for the unsigned step),
    // product and saturation working widths.
    localparam int W   = FRACTION_BITS + 4;
    localparam int MW  = (W > STEP_W + 1) ? W : STEP_W + 1;
    localparam int PW  = 2 * MW;
    localparam int SW  = PW + 2;
    localparam int IW0 = $clog2(MAX_ITERATIONS + 1);
    localparam int IW  = (IW0 > GRAY_W) ? IW0 : GRAY_W;

    localparam logic signed [W-1:0]  Q_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  Q_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [SW-1:0] TWO   = SW'(2) <<< FRACTION_BITS;
    localparam logic [PW-1:0]        LIMIT = PW'(4) << (2 * FRACTION_BITS);
    localparam logic [IW-1:0]        ITER_LAST = IW'(MAX_ITERATIONS);

    typedef enum logic [3:0] {
        S_IDLE, S_C0, S_C1, S_C2, S_C3, S_XX, S_YY, S_XY, S_UPD, S_DONE
    } t_state;

    t_state                   r_state;
    logic [STEP_W-1:0]        r_pixel_step;
    logic [HEIGHT_W-1:0]      r_image_height;
    logic [COORD_BITS-1:0]    r_px;
    logic [COORD_BITS-1:0]    r_py;
    logic signed [PW-1:0]     r_prod;
    logic signed [PW-1:0]     r_acc;
    logic signed [W-1:0]      r_cx;
    logic signed [W-1:0]      r_cy;
    logic signed [W-1:0]      r_zx;
    logic signed [W-1:0]      r_zy;
    logic [IW-1:0]            r_iter;
    logic [GRAY_W-1:0]        r_level;
    logic                     r_esc;
    logic                     r_out_valid;
    logic [GRAY_W-1:0]        r_gray_level;
    logic                     r_escaped;

    logic signed [MW-1:0]     mul_a;
    logic signed [MW-1:0]     mul_b;
    logic signed [PW-1:0]     n_prod;
    logic [PW-1:0]            n_mag;
    logic                     n_escape;
    logic [IW-1:0]            n_level;
    logic signed [W-1:0]      n_cx;
    logic signed [W-1:0]      n_cy;
    logic signed [W-1:0]      n_zx;
    logic signed [W-1:0]      n_zy;
    logic                     out_free;

    function automatic logic signed [W-1:0] f_sat(input logic signed [SW-1:0] v);
        logic signed [W-1:0] res;
        if (v > SW'(Q_MAX)) begin
            res = Q_MAX;
        end else if (v < SW'(Q_MIN)) begin
            res = Q_MIN;
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_C0: begin
                mul_a = $signed(MW'(r_pixel_step));
                mul_b = $signed(MW'(r_image_height));
            end
            S_C1: begin
                mul_a = $signed(MW'(r_pixel_step));
                mul_b = $signed(MW'(r_px));
            end
            S_C2: begin
                mul_a = $signed(MW'(r_pixel_step));
                mul_b = $signed(MW'(r_py));
            end
            S_XX: begin
                mul_a = MW'(r_zx);
                mul_b = MW'(r_zx);
            end
            S_YY: begin
                mul_a = MW'(r_zy);
                mul_b = MW'(r_zy);
            end
            S_XY: begin
                mul_a = MW'(r_zx);
                mul_b = MW'(r_zy);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    // In S_XY, r_acc holds zx^2 and r_prod holds zy^2 of the latest z.
    assign n_mag    = $unsigned(r_acc) + $unsigned(r_prod);
    assign n_escape = (r_iter != '0) && (n_mag > LIMIT);
    assign n_level  = r_iter - 1'b1;

    assign n_cx = f_sat(SW'(r_prod) - TWO);
    assign n_cy = f_sat(SW'(r_prod) - SW'(r_acc));
    // In S_UPD, r_acc holds xx - yy and r_prod holds xy; doubling xy is one
    // bit less of shift.
    assign n_zx = f_sat(SW'(r_acc >>> FRACTION_BITS) + SW'(r_cx));
    assign n_zy = f_sat(SW'(r_prod >>> (FRACTION_BITS - 1)) + SW'(r_cy));

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pixel_step   <= STEP_RESET;
            r_image_height <= HEIGHT_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PIXEL_STEP:   r_pixel_step   <= i_cfg_data[STEP_W-1:0];
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[HEIGHT_W-1:0];
                    default: ;
                endcase
            end

            // In the final state the output register is loaded instead.
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_px    <= i_pixel_x;
                        r_py    <= i_pixel_y;
                        r_state <= S_C0;
                    end
                end
                S_C0: begin
                    r_state <= S_C1;
                end
                S_C1: begin
                    // Imaginary offset is half of step * height, rounded down.
                    r_acc   <= r_prod >>> 1;
                    r_state <= S_C2;
                end
                S_C2: begin
                    r_cx    <= n_cx;
                    r_state <= S_C3;
                end
                S_C3: begin
                    r_cy    <= n_cy;
                    r_zx    <= '0;
                    r_zy    <= '0;
                    r_iter  <= '0;
                    r_state <= S_XX;
                end
                S_XX: begin
                    r_state <= S_YY;
                end
                S_YY: begin
                    r_acc   <= r_prod;
                    r_state <= S_XY;
                end
                S_XY: begin
                    r_acc <= r_acc - r_prod;
                    if (n_escape) begin
                        r_level <= n_level[GRAY_W-1:0];
                        r_esc   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_iter == ITER_LAST) begin
                        r_level <= '0;
                        r_esc   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_zx    <= n_zx;
                    r_zy    <= n_zy;
                    r_iter  <= r_iter + 1'b1;
                    r_state <= S_XX;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_gray_level <= r_level;
                        r_escaped    <= r_esc;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_gray_level = r_gray_level;
    assign o_escaped    = r_escaped;

    // The round counter never passes the iteration limit.
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XX || r_state == S_YY || r_state == S_XY || r_state == S_UPD)
        |-> (r_iter <= ITER_LAST))
        else $error("round counter beyond iteration limit");

    // A point that never escaped is reported as black.
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_escaped) |-> (o_gray_level == '0))
        else $error("non-escaped result with non-zero level");

    // A new result only appears when a pixel has just finished.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the final state");

    // An accepted transaction starts the set-up of c in the next cycle.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_C0 && o_in_stall))
        else $error("accepted pixel did not start evaluation");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the escape-time counter: pixel transactions are
// queued by a stimulus sequence, sent by a clocked driver with random gaps,
// and each result is checked against an in-bench fixed-point iteration.
// ----------------------------------------------------------------------------
module tb_top;
    import mec_pkg::*;

    localparam int  MAX_ITER   = 255;
    localparam int  COORD_W    = 12;
    localparam int  FRAC       = 28;
    localparam int  CYCLE_CAP  = 4_000_000;
    localparam longint FULL_SPAN = 64'd671088640;   // 2.5 in Q4.28

    typedef struct packed {
        logic [GRAY_W-1:0] gray_level;
        logic              escaped;
    } t_escape_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    logic [COORD_W-1:0]    pixel_x = '0;
    logic [COORD_W-1:0]    pixel_y = '0;
    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    logic [GRAY_W-1:0]     o_gray_level;
    logic                  o_escaped;
    logic                  cfg_we;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [2*COORD_W-1:0]  pixel_q[$];
    t_escape_result        escape_q[$];
    logic [STEP_W-1:0]     step_reg;
    logic [HEIGHT_W-1:0]   height_reg;
    logic                  in_taken = 1'b0;
    bit                    quiet;
    int                    mismatch_cnt = 0;
    int                    in_gap = 0;
    int                    stall_left = 0;
    longint                cycle_cnt = 0;

    mandelbrot_escape_counter #(
        .MAX_ITERATIONS (MAX_ITER),
        .COORD_BITS     (COORD_W),
        .FRACTION_BITS  (FRAC)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel_x    (pixel_x),
        .i_pixel_y    (pixel_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_gray_level (o_gray_level),
        .o_escaped    (o_escaped),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint clamp_q(input longint v);
        longint hi;
        hi = (longint'(1) <<< (FRAC + 3)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Iterates z = z^2 + c in signed Q4.28; squares stay exact for the bound test.
    function automatic t_escape_result predict_escape(input logic [COORD_W-1:0] px,
                                                      input logic [COORD_W-1:0] py);
        longint          cx, cy, zx, zy, nx, ny, offset;
        longint unsigned bound, mag;
        t_escape_result  res;
        int              i;
        offset = (longint'(step_reg) * longint'(height_reg)) >>> 1;
        cx     = clamp_q(longint'(px) * longint'(step_reg) - (longint'(2) <<< FRAC));
        cy     = clamp_q(longint'(py) * longint'(step_reg) - offset);
        bound  = longint'(4) << (2 * FRAC);
        zx     = 0;
        zy     = 0;
        res    = '0;
        for (i = 0; i < MAX_ITER; i++) begin
            nx  = clamp_q(((zx * zx - zy * zy) >>> FRAC) + cx);
            ny  = clamp_q(((zx * zy) >>> (FRAC - 1)) + cy);
            zx  = nx;
            zy  = ny;
            mag = longint'(zx * zx) + longint'(zy * zy);
            if (mag > bound) begin
                res.gray_level = i[GRAY_W-1:0];
                res.escaped    = 1'b1;
                break;
            end
        end
        return res;
    endfunction

    // Acceptance is noted at the rising edge so that the driver can advance.
    always @(posedge i_clk) begin
        in_taken <= in_valid && !o_in_stall;
        if (in_valid && !o_in_stall) begin
            escape_q.push_back(predict_escape(pixel_x, pixel_y));
        end
    end

    always @(negedge i_clk) begin
        if (!in_valid || in_taken) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap = in_gap - 1;
            end else if (pixel_q.size() > 0) begin
                {pixel_x, pixel_y} <= pixel_q.pop_front();
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(1, 14);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 13);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_escape_result want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (escape_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected result: gray %0d escaped %0b",
                             o_gray_level, o_escaped);
                end
            end else begin
                want = escape_q.pop_front();
                if (o_gray_level !== want.gray_level || o_escaped !== want.escaped) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("mismatch: gray exp %0d got %0d, escaped exp %0b got %0b",
                                 want.gray_level, o_gray_level, want.escaped, o_escaped);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic add_pixel(input int x, input int y);
        pixel_q.push_back({x[COORD_W-1:0], y[COORD_W-1:0]});
    endtask

    // Waits until every queued transaction has gone in and every result come out.
    task automatic wait_idle();
        while (pixel_q.size() != 0 || in_valid || escape_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_PIXEL_STEP) step_reg = data[STEP_W-1:0];
        else height_reg = data[HEIGHT_W-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] step,
                              input logic [CFG_DATA_W-1:0] height);
        wait_idle();
        write_reg(CFG_PIXEL_STEP, step);
        write_reg(CFG_IMAGE_HEIGHT, height);
        @(posedge i_clk);
    endtask

    // Mostly pixels inside the image that the settings describe, some anywhere.
    task automatic random_pixels(input int count);
        longint cols, rows;
        cols = (step_reg == 0) ? 4096 : FULL_SPAN / longint'(step_reg);
        if (cols < 1) cols = 1;
        if (cols > 4096) cols = 4096;
        rows = (height_reg == 0) ? 1 : longint'(height_reg);
        if (rows > 4096) rows = 4096;
        repeat (count) begin
            if ($urandom_range(0, 99) < 85) begin
                add_pixel($urandom_range(0, int'(cols) - 1), $urandom_range(0, int'(rows) - 1));
            end else begin
                add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_PIXEL_STEP;
        cfg_data     = '0;
        quiet        = 1'b0;
        step_reg     = STEP_RESET;
        height_reg   = HEIGHT_RESET;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: corners, alternating bits, interior and boundary points.
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(0, 4095);
        add_pixel(4095, 0);
        add_pixel(12'hAAA, 12'h555);
        add_pixel(12'h555, 12'hAAA);
        add_pixel(512, 512);
        add_pixel(400, 512);
        add_pixel(1000, 512);
        add_pixel(560, 690);

        // With no step every pixel lands on c = -2, which never escapes.
        set_config(0, 0);
        add_pixel(0, 0);
        add_pixel(4095, 4095);

        // No height leaves the imaginary axis uncentred.
        set_config(STEP_RESET, 0);
        add_pixel(600, 0);
        add_pixel(700, 300);

        // Widest step of the random range: most points saturate and escape at once.
        set_config(30'd671088640, 4096);
        add_pixel(0, 0);
        add_pixel(1, 2048);
        add_pixel(4095, 4095);

        // Full-width register values.
        set_config(30'h3FFF_FFFF, 8191);
        add_pixel(0, 0);
        add_pixel(0, 1);
        add_pixel(4095, 4095);

        set_config(30'd2621440, 256);
        random_pixels(200);
        set_config(30'd10485760, 48);
        random_pixels(150);
        set_config(STEP_RESET, 768);
        random_pixels(150);
        set_config(30'd163840, 4096);
        random_pixels(100);
        set_config(CFG_DATA_W'($urandom_range(163840, 671088640)),
                   CFG_DATA_W'($urandom_range(1, 4096)));
        wait_idle();
        quiet = 1'b1;
        random_pixels(100);

        wait_idle();
        repeat (60) @(posedge i_clk);
        if (escape_q.size() != 0) begin
            $display("%0d results never arrived", escape_q.size());
        end
        if (mismatch_cnt == 0 && escape_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/mec_pkg.sv
sv/mandelbrot_escape_counter.sv
dv/tb_top.sv
